>>> rtl/depth_sorted_render_queue_assert.svh
// Assertion macros for the depth-sorted render queue.
// No dependencies; taken in by the files that carry assertions.
`ifndef DEPTH_SORTED_RENDER_QUEUE_ASSERT_SVH
`define DEPTH_SORTED_RENDER_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DSRQ_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dsrq assertion failed");

// Next-cycle implication, checked out of reset.
`define DSRQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dsrq assertion failed");

`endif

>>> rtl/dsrq_pkg.sv
// Shared types and constants of the depth-sorted render queue.
// No dependencies; used by dsrq_cell and depth_sorted_render_queue.
package dsrq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CountW      = $clog2(QUEUE_DEPTH + 1);

  localparam int KeyW   = 32;
  localparam int ScaleW = 32;
  localparam int PosW   = 12;
  localparam int DrawW  = 13;
  localparam int AnimW  = 8;
  localparam int SliceW = 10;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_e;

  typedef struct packed {
    logic signed [KeyW-1:0]  key;
    logic [ScaleW-1:0]       scale;
    logic signed [DrawW-1:0] draw_x;
    logic [AnimW-1:0]        anim;
    logic [SliceW-1:0]       slice;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    entry_t   new_entry;
  } cell_ctrl_t;

endpackage

>>> rtl/depth_sorted_render_queue.sv
// Top level of the depth-sorted render queue: chain of dsrq_cell slots plus result register.
// Depends on dsrq_pkg, dsrq_cell and depth_sorted_render_queue_assert.svh.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------------------------
//   in      | input     | in_valid_i/in_ready_o  | command, sort key, scale, x, comp, anim, slice
//   out     | output    | out_valid_o/out_ready_i| status, entry valid, draw x, scale, anim, slice,
//           |           |                        | entries left
//
// Every command completes at the edge that accepts the beat: the whole chain updates there,
// and the result lands in the output register at the same edge.
// Insert compares the new key against every slot in parallel; pop shifts the chain by one.
// A new beat is taken whenever the result register is empty or is being drained.
// Reset clears the entry count and the result valid flag; slot contents are left as they are.
// A stall on the output side holds the result and stops input acceptance; nothing is lost.
`include "depth_sorted_render_queue_assert.svh"

module depth_sorted_render_queue (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          command_i,
  input  logic signed [dsrq_pkg::KeyW-1:0]    sort_key_i,
  input  logic [dsrq_pkg::ScaleW-1:0]         draw_scale_i,
  input  logic signed [dsrq_pkg::PosW-1:0]    x_position_i,
  input  logic signed [dsrq_pkg::PosW-1:0]    x_compensation_i,
  input  logic [dsrq_pkg::AnimW-1:0]          anim_id_i,
  input  logic [dsrq_pkg::SliceW-1:0]         slice_id_i,

  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          status_o,
  output logic                                entry_valid_o,
  output logic signed [dsrq_pkg::DrawW-1:0]   out_draw_x_o,
  output logic [dsrq_pkg::ScaleW-1:0]         out_scale_o,
  output logic [dsrq_pkg::AnimW-1:0]          out_anim_o,
  output logic [dsrq_pkg::SliceW-1:0]         out_slice_o,
  output logic [dsrq_pkg::CountW-1:0]         entries_left_o
);

  localparam int N = dsrq_pkg::QUEUE_DEPTH;

  // Handshake
  logic out_valid_q;
  logic in_fire;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Entry count and command decode
  logic [dsrq_pkg::CountW-1:0] count_q, count_d;
  logic                        is_full, is_empty;
  logic                        do_insert, do_pop, do_clear;

  assign is_full   = (count_q == dsrq_pkg::CountW'(N));
  assign is_empty  = (count_q == '0);
  assign do_insert = in_fire && (command_i == dsrq_pkg::CMD_INSERT) && !is_full;
  assign do_pop    = in_fire && (command_i == dsrq_pkg::CMD_POP) && !is_empty;
  assign do_clear  = in_fire && (command_i == dsrq_pkg::CMD_CLEAR);

  always_comb begin
    count_d = count_q;
    if (do_clear) begin
      count_d = '0;
    end else if (do_insert) begin
      count_d = count_q + 1'b1;
    end else if (do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  // Broadcast control: the new entry carries its draw position, summed once here
  dsrq_pkg::cell_ctrl_t ctrl;
  always_comb begin
    ctrl.new_entry.key    = sort_key_i;
    ctrl.new_entry.scale  = draw_scale_i;
    ctrl.new_entry.draw_x = dsrq_pkg::DrawW'(x_position_i) + dsrq_pkg::DrawW'(x_compensation_i);
    ctrl.new_entry.anim   = anim_id_i;
    ctrl.new_entry.slice  = slice_id_i;
    if (do_insert) begin
      ctrl.op = dsrq_pkg::OP_INSERT;
    end else if (do_pop) begin
      ctrl.op = dsrq_pkg::OP_POP;
    end else begin
      ctrl.op = dsrq_pkg::OP_HOLD;
    end
  end

  // Chain of slots: slot 0 is the head (largest key)
  dsrq_pkg::entry_t ent       [N];
  dsrq_pkg::entry_t left_ent  [N];
  dsrq_pkg::entry_t right_ent [N];
  logic [N-1:0]     stay;
  logic [N-1:0]     left_stay;
  logic [N-1:0]     occ;

  for (genvar i = 0; i < N; i++) begin : g_chain
    // a slot is occupied while its index is below the entry count
    assign occ[i] = (count_q > dsrq_pkg::CountW'(i));

    if (i == 0) begin : g_head
      assign left_ent[i]  = ctrl.new_entry;
      assign left_stay[i] = 1'b1;
    end else begin : g_body
      assign left_ent[i]  = ent[i-1];
      assign left_stay[i] = stay[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_ent[i] = ent[i];
    end else begin : g_inner
      assign right_ent[i] = ent[i+1];
    end

    dsrq_cell u_slot (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ[i]),
      .left_stay_i (left_stay[i]),
      .left_i      (left_ent[i]),
      .right_i     (right_ent[i]),
      .entry_o     (ent[i]),
      .stay_o      (stay[i])
    );
  end

  // Result register: hold until the downstream side takes the beat
  logic [1:0]                        status_q;
  logic                              entry_valid_q;
  logic signed [dsrq_pkg::DrawW-1:0] draw_x_q;
  logic [dsrq_pkg::ScaleW-1:0]       scale_q;
  logic [dsrq_pkg::AnimW-1:0]        anim_q;
  logic [dsrq_pkg::SliceW-1:0]       slice_q;
  logic [dsrq_pkg::CountW-1:0]       left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: entry fields are zero unless a head entry is popped
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      status_q      <= dsrq_pkg::ST_DONE;
      entry_valid_q <= do_pop;
      draw_x_q      <= do_pop ? ent[0].draw_x : '0;
      scale_q       <= do_pop ? ent[0].scale  : '0;
      anim_q        <= do_pop ? ent[0].anim   : '0;
      slice_q       <= do_pop ? ent[0].slice  : '0;
      left_q        <= count_d;
      if ((command_i == dsrq_pkg::CMD_INSERT) && is_full) begin
        status_q <= dsrq_pkg::ST_FULL;
      end else if ((command_i == dsrq_pkg::CMD_POP) && is_empty) begin
        status_q <= dsrq_pkg::ST_EMPTY;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign entry_valid_o  = entry_valid_q;
  assign out_draw_x_o   = draw_x_q;
  assign out_scale_o    = scale_q;
  assign out_anim_o     = anim_q;
  assign out_slice_o    = slice_q;
  assign entries_left_o = left_q;

  // Checks
  `DSRQ_ASSERT_IMPL(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= dsrq_pkg::CountW'(N))
  `DSRQ_ASSERT_IMPL(a_stay_prefix, clk_i, rst_ni, 1'b1, (stay & ~{stay[N-2:0], 1'b1}) == '0)
  `DSRQ_ASSERT_NEXT(a_insert_grows, clk_i, rst_ni, do_insert, count_q == $past(count_q) + 1'b1)
  `DSRQ_ASSERT_IMPL(a_pop_status, clk_i, rst_ni, out_valid_q && entry_valid_q,
                    status_q == dsrq_pkg::ST_DONE)

endmodule

>>> rtl/dsrq_cell.sv
// One slot of the sorted chain: holds an entry, compares it with the broadcast key.
// Depends on dsrq_pkg.
module dsrq_cell (
  input  logic                clk_i,
  input  dsrq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                left_stay_i,
  input  dsrq_pkg::entry_t    left_i,
  input  dsrq_pkg::entry_t    right_i,
  output dsrq_pkg::entry_t    entry_o,
  output logic                stay_o
);

  dsrq_pkg::entry_t entry_q, entry_d;

  // keep the slot if it is occupied and its key is greater or equal (stable order)
  assign stay_o  = occ_i && (entry_q.key >= ctrl_i.new_entry.key);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      dsrq_pkg::OP_INSERT: begin
        if (!stay_o) begin
          entry_d = left_stay_i ? ctrl_i.new_entry : left_i;
        end
      end
      dsrq_pkg::OP_POP: begin
        entry_d = right_i;
      end
      default: begin
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

>>> test/tb_top.sv
// Self-checking bench for depth_sorted_render_queue: sorted-list predictor and result scoreboard.
// Depends on dsrq_pkg and the depth_sorted_render_queue RTL; reads no files.

// Command code 3 is not used by the block: it must leave the list alone.
localparam logic [1:0] CMD_UNUSED = 2'd3;

typedef struct packed {
  logic [1:0]                         command;
  logic signed [dsrq_pkg::KeyW-1:0]   sort_key;
  logic [dsrq_pkg::ScaleW-1:0]        draw_scale;
  logic signed [dsrq_pkg::PosW-1:0]   x_position;
  logic signed [dsrq_pkg::PosW-1:0]   x_compensation;
  logic [dsrq_pkg::AnimW-1:0]         anim_id;
  logic [dsrq_pkg::SliceW-1:0]        slice_id;
} command_beat_t;

typedef struct packed {
  logic [1:0]                         status;
  logic                               entry_valid;
  logic signed [dsrq_pkg::DrawW-1:0]  draw_x;
  logic [dsrq_pkg::ScaleW-1:0]        scale;
  logic [dsrq_pkg::AnimW-1:0]         anim;
  logic [dsrq_pkg::SliceW-1:0]        slice;
  logic [dsrq_pkg::CountW-1:0]        entries_left;
} draw_result_t;

class render_queue_scoreboard;
  dsrq_pkg::entry_t sorted_list[$];   // head (largest key) at index 0
  draw_result_t     expected_q[$];
  int               fail_count = 0;

  // Apply one accepted command to the list and queue the result it must give.
  function void note_beat(command_beat_t b);
    draw_result_t     r;
    dsrq_pkg::entry_t e;
    int               pos;
    r = '0;
    case (b.command)
      dsrq_pkg::CMD_INSERT: begin
        if (sorted_list.size() >= dsrq_pkg::QUEUE_DEPTH) begin
          r.status = dsrq_pkg::ST_FULL;
        end else begin
          e.key    = b.sort_key;
          e.scale  = b.draw_scale;
          e.draw_x = $signed({b.x_position[dsrq_pkg::PosW-1], b.x_position})
                   + $signed({b.x_compensation[dsrq_pkg::PosW-1], b.x_compensation});
          e.anim   = b.anim_id;
          e.slice  = b.slice_id;
          // Stable: go past every stored entry whose key is greater or equal.
          pos = 0;
          while (pos < sorted_list.size() && $signed(sorted_list[pos].key) >= $signed(e.key))
            pos++;
          sorted_list.insert(pos, e);
        end
      end
      dsrq_pkg::CMD_POP: begin
        if (sorted_list.size() == 0) begin
          r.status = dsrq_pkg::ST_EMPTY;
        end else begin
          e = sorted_list.pop_front();
          r.entry_valid = 1'b1;
          r.draw_x      = e.draw_x;
          r.scale       = e.scale;
          r.anim        = e.anim;
          r.slice       = e.slice;
        end
      end
      dsrq_pkg::CMD_CLEAR: sorted_list.delete();
      default: ;
    endcase
    r.entries_left = dsrq_pkg::CountW'(sorted_list.size());
    expected_q.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      fail_count++;
    end
  endfunction

  function void check_result(draw_result_t got);
    draw_result_t want;
    if (expected_q.size() == 0) begin
      $error("result beat with no command waiting");
      fail_count++;
    end else begin
      want = expected_q.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
      compare_field("out_draw_x", 32'(want.draw_x), 32'(got.draw_x));
      compare_field("out_scale", want.scale, got.scale);
      compare_field("out_anim", 32'(want.anim), 32'(got.anim));
      compare_field("out_slice", 32'(want.slice), 32'(got.slice));
      compare_field("entries_left", 32'(want.entries_left), 32'(got.entries_left));
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module tb_top;
  localparam int RANDOM_BEATS    = 1850;
  localparam int WATCHDOG_LIMIT  = 2000;  // quiet cycles; the long hold-off is well below this
  localparam int HOLD_OFF_AT     = 400;   // result count at which the sink goes quiet
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_CYCLES    = 4;

  logic                              clk_i;
  logic                              rst_ni           = 1'b0;
  logic                              in_valid_i       = 1'b0;
  logic                              in_ready_o;
  logic [1:0]                        command_i        = '0;
  logic signed [dsrq_pkg::KeyW-1:0]  sort_key_i       = '0;
  logic [dsrq_pkg::ScaleW-1:0]       draw_scale_i     = '0;
  logic signed [dsrq_pkg::PosW-1:0]  x_position_i     = '0;
  logic signed [dsrq_pkg::PosW-1:0]  x_compensation_i = '0;
  logic [dsrq_pkg::AnimW-1:0]        anim_id_i        = '0;
  logic [dsrq_pkg::SliceW-1:0]       slice_id_i       = '0;
  logic                              out_valid_o;
  logic                              out_ready_i      = 1'b0;
  logic [1:0]                        status_o;
  logic                              entry_valid_o;
  logic signed [dsrq_pkg::DrawW-1:0] out_draw_x_o;
  logic [dsrq_pkg::ScaleW-1:0]       out_scale_o;
  logic [dsrq_pkg::AnimW-1:0]        out_anim_o;
  logic [dsrq_pkg::SliceW-1:0]       out_slice_o;
  logic [dsrq_pkg::CountW-1:0]       entries_left_o;

  render_queue_scoreboard sb;
  int beats_sent   = 0;
  int results_seen = 0;

  depth_sorted_render_queue dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic command_beat_t make_beat(logic [1:0] cmd, logic [31:0] key,
                                              logic [31:0] scale, logic [11:0] xpos,
                                              logic [11:0] xcomp, logic [7:0] anim,
                                              logic [9:0] slice);
    command_beat_t b;
    b.command        = cmd;
    b.sort_key       = key;
    b.draw_scale     = scale;
    b.x_position     = xpos;
    b.x_compensation = xcomp;
    b.anim_id        = anim;
    b.slice_id       = slice;
    return b;
  endfunction

  // Random payload; keys lean towards a few coarse depths so that ties are common,
  // with the signed extremes thrown in now and then.
  function automatic command_beat_t random_beat(logic [1:0] cmd);
    logic [31:0] key;
    int          depth;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0:       key = 32'h7fff_ffff;
          1:       key = 32'h8000_0000;
          2:       key = 32'h0000_0000;
          default: key = 32'hffff_ffff;
        endcase
      end
      1, 2: begin
        depth = int'($urandom_range(0, 15)) - 8;
        key   = 32'(depth <<< 16);
      end
      default: key = $urandom;
    endcase
    // Now and then swap in a stray command code, the unused one included.
    if ($urandom_range(0, 11) == 0) cmd = 2'($urandom_range(0, 3));
    return make_beat(cmd, key, $urandom, 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
                     10'($urandom_range(0, 1023)));
  endfunction

  // Offer one beat and hold it until the block takes it. Every fourth hundred beats
  // go back to back so that stretches without idling occur.
  task automatic send_beat(command_beat_t b);
    int gap;
    gap = ((beats_sent / 100) % 4 == 1) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    command_i        <= b.command;
    sort_key_i       <= b.sort_key;
    draw_scale_i     <= b.draw_scale;
    x_position_i     <= b.x_position;
    x_compensation_i <= b.x_compensation;
    anim_id_i        <= b.anim_id;
    slice_id_i       <= b.slice_id;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(b);
    beats_sent++;
  endtask

  // One frame: usually a clear, a run of inserts (sometimes past the list size),
  // then a drain of pops that may run past empty.
  task automatic random_frame();
    int fill;
    int drain;
    if ($urandom_range(0, 7) != 0) send_beat(random_beat(dsrq_pkg::CMD_CLEAR));
    fill = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 24);
    repeat (fill) send_beat(random_beat(dsrq_pkg::CMD_INSERT));
    drain = $urandom_range(0, fill + 4);
    repeat (drain) send_beat(random_beat(dsrq_pkg::CMD_POP));
  endtask

  // Stimulus and end of run.
  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: pop on empty, field extremes, signed key order, ties, the unused code.
    send_beat(make_beat(dsrq_pkg::CMD_POP, 32'h0, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));
    send_beat(make_beat(dsrq_pkg::CMD_INSERT, 32'h0, 32'hffff_ffff, 12'h7ff, 12'h7ff,
                        8'hff, 10'h3ff));
    send_beat(make_beat(dsrq_pkg::CMD_INSERT, 32'h0, 32'h0, 12'h800, 12'h800, 8'h00, 10'h000));
    send_beat(make_beat(dsrq_pkg::CMD_INSERT, 32'h7fff_ffff, 32'h0001_0000, 12'h001, 12'hfff,
                        8'h01, 10'h1));
    send_beat(make_beat(dsrq_pkg::CMD_INSERT, 32'h8000_0000, 32'h0000_8000, 12'h7ff, 12'h800,
                        8'h02, 10'h2));
    send_beat(make_beat(dsrq_pkg::CMD_INSERT, 32'hffff_ffff, 32'haaaa_5555, 12'h555, 12'haaa,
                        8'h55, 10'h155));
    send_beat(make_beat(dsrq_pkg::CMD_INSERT, 32'h0000_0001, 32'h5555_aaaa, 12'haaa, 12'h555,
                        8'haa, 10'h2aa));
    send_beat(make_beat(CMD_UNUSED, 32'h1234_5678, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));
    repeat (7) send_beat(make_beat(dsrq_pkg::CMD_POP, 32'h0, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));
    send_beat(random_beat(dsrq_pkg::CMD_INSERT));
    send_beat(random_beat(dsrq_pkg::CMD_INSERT));
    send_beat(make_beat(dsrq_pkg::CMD_CLEAR, 32'h0, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));
    send_beat(make_beat(dsrq_pkg::CMD_POP, 32'h0, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));
    send_beat(make_beat(CMD_UNUSED, 32'h0, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));
    send_beat(random_beat(dsrq_pkg::CMD_INSERT));
    send_beat(make_beat(dsrq_pkg::CMD_CLEAR, 32'h0, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));
    send_beat(make_beat(dsrq_pkg::CMD_CLEAR, 32'h0, 32'h0, 12'h0, 12'h0, 8'h0, 10'h0));

    // Random frames until enough beats have gone in.
    while (beats_sent < RANDOM_BEATS) random_frame();
    in_valid_i <= 1'b0;

    // Drain: wait for every result, then wait out DRAIN_CYCLES for anything stray.
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  // Result sink: random stalls, quiet stretches, and one long hold-off that
  // backs the block up until it refuses input.
  initial begin
    int           stall;
    draw_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      if (results_seen == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      else if ((results_seen / 90) % 5 == 2) stall = 0;
      else stall = $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      got.status       = status_o;
      got.entry_valid  = entry_valid_o;
      got.draw_x       = out_draw_x_o;
      got.scale        = out_scale_o;
      got.anim         = out_anim_o;
      got.slice        = out_slice_o;
      got.entries_left = entries_left_o;
      sb.check_result(got);
      results_seen++;
    end
  end

  // Watchdog: give up once neither channel has moved a beat for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL");
    $finish;
  end
endmodule

>>> sim.f
+incdir+rtl
rtl/dsrq_pkg.sv
rtl/dsrq_cell.sv
rtl/depth_sorted_render_queue.sv
test/tb_top.sv
